[hw/rtl/tm_pkg.sv]
// Shared constants, tables and latency helpers for the triangle measurement pipeline.
package tm_pkg;

	localparam logic [1:0] SEL_NONE = 2'd0;
	localparam logic [1:0] SEL_A    = 2'd1;
	localparam logic [1:0] SEL_B    = 2'd2;
	localparam logic [1:0] SEL_C    = 2'd3;

	localparam int AREA_W  = 33;
	localparam int PERIM_W = 27;
	localparam int ANGLE_W = 16;

	localparam int Q8_FRAC      = 8;
	localparam int NORM_LSB     = 40;
	localparam int CORDIC_W     = 45;
	localparam int Z_W          = 26;
	localparam int CORDIC_STEPS = 23;
	localparam int ANGLE_MAX    = 46080;
	localparam int ROUND_HALF   = 128;
	localparam int Z_RIGHT      = 90 * 65536;

	localparam logic [21:0] ATAN_Q16 [CORDIC_STEPS] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
		22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2, 22'd1
	};

	// root bits of one digit-by-digit square root stage chain
	function automatic int sqrt_steps(input int cb);
		return cb + 9;
	endfunction

	// stages from crs/dot input to registered angle
	function automatic int angle_lat(input int cb);
		return 2 + $clog2(2 * cb + 2) + CORDIC_STEPS + 1;
	endfunction

endpackage

[hw/rtl/triangle_measure.sv]
// Top level of the triangle measurement pipeline.
// Measures one triangle per transaction.
// Input stream s_*: tdata carries the six vertex coordinates (ax, ay, bx, by_coord,
// cx, cy, COORD_BITS each, lowest first); tuser carries which_angle (1 = A,
// 2 = B, 3 = C, 0 invalid).
// Output stream m_*: tdata carries area_doubled, perimeter_q8, angle_deg_q8 from
// bit 0 up; tuser carries error_flag.
// Throughput is one transaction per cycle while m_tready does not stall the pipeline.
// A transaction passes through 4 + max(COORD_BITS + 9, 3 + clog2(2*COORD_BITS + 2) + 23)
// register stages (36 at 16 bits): three front stages of products and sums, then the
// longer of the square root chain (one root bit per stage) and the angle path (setup,
// normalize steps, 23 CORDIC stages and rounding), then the output register.
// The whole pipeline advances as one; when the receiver holds m_tready low with a
// result waiting, every stage freezes and s_tready drops, so nothing is lost or
// repeated. Reset clears all valid bits; the data registers have no reset.
module triangle_measure #(
	parameter int COORD_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// ax, ay, bx, by_coord, cx, cy, zero padding
	input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// which_angle
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// area_doubled, perimeter_q8, angle_deg_q8, zero padding
	output logic [79:0]                       m_tdata,
	// error_flag
	output logic                              m_tuser
);

	localparam int CB  = COORD_BITS;
	localparam int LW  = 2 * CB + 1;
	localparam int MW  = 2 * CB + 1;
	localparam int NIT = tm_pkg::sqrt_steps(CB);
	localparam int LA  = tm_pkg::angle_lat(CB);
	localparam int DA  = (NIT > LA) ? NIT - LA : 0;
	localparam int DP  = (LA > NIT) ? LA - NIT : 0;
	localparam int VD  = 3 + ((NIT > LA) ? NIT : LA);
	localparam int SW  = NIT + 2;
	localparam int AOW = MW + tm_pkg::ANGLE_W + 1;

	logic                 en;
	logic [VD-1:0]        vld_s;
	logic                 out_vld_q;

	logic signed [2*CB+1:0] crs, dot;
	logic [LW-1:0]          len_ab, len_ac, len_bc;
	logic                   err_f;

	logic [NIT-1:0]   rt_ab, rt_ac, rt_bc;
	logic [3*NIT-1:0] rt_d;
	logic [MW-1:0]    area_a;
	logic [tm_pkg::ANGLE_W-1:0] ang_a;
	logic             err_a;
	logic [AOW-1:0]   ao_d;

	logic [SW-1:0]    perim_sum;
	logic [tm_pkg::AREA_W-1:0]  area_fit;
	logic [tm_pkg::PERIM_W-1:0] perim_fit;

	logic [tm_pkg::AREA_W-1:0]  area_q;
	logic [tm_pkg::PERIM_W-1:0] perim_q;
	logic [tm_pkg::ANGLE_W-1:0] angle_q;
	logic                       err_q;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	tm_front #(.CB(CB)) u_front (
		.clk         (clk),
		.en          (en),
		.ax          (s_tdata[0*CB +: CB]),
		.ay          (s_tdata[1*CB +: CB]),
		.bx          (s_tdata[2*CB +: CB]),
		.by_coord    (s_tdata[3*CB +: CB]),
		.cx          (s_tdata[4*CB +: CB]),
		.cy          (s_tdata[5*CB +: CB]),
		.which_angle (s_tuser),
		.crs         (crs),
		.dot         (dot),
		.len_ab      (len_ab),
		.len_ac      (len_ac),
		.len_bc      (len_bc),
		.err         (err_f)
	);

	tm_sqrt #(.CB(CB)) u_sqrt_ab (.clk(clk), .en(en), .n(len_ab), .root(rt_ab));
	tm_sqrt #(.CB(CB)) u_sqrt_ac (.clk(clk), .en(en), .n(len_ac), .root(rt_ac));
	tm_sqrt #(.CB(CB)) u_sqrt_bc (.clk(clk), .en(en), .n(len_bc), .root(rt_bc));

	tm_angle #(.CB(CB)) u_angle (
		.clk     (clk),
		.en      (en),
		.crs     (crs),
		.dot     (dot),
		.err     (err_f),
		.area    (area_a),
		.angle   (ang_a),
		.err_out (err_a)
	);

	tm_delay #(.WIDTH(3*NIT), .DEPTH(DP)) u_dly_root (
		.clk (clk), .en (en), .d ({rt_bc, rt_ac, rt_ab}), .q (rt_d)
	);

	tm_delay #(.WIDTH(AOW), .DEPTH(DA)) u_dly_ang (
		.clk (clk), .en (en), .d ({err_a, ang_a, area_a}), .q (ao_d)
	);

	assign perim_sum = {2'b00, rt_d[0 +: NIT]} + {2'b00, rt_d[NIT +: NIT]}
		+ {2'b00, rt_d[2*NIT +: NIT]};

	generate
		if (MW >= tm_pkg::AREA_W) begin : g_area_cut
			assign area_fit = ao_d[tm_pkg::AREA_W-1:0];
		end else begin : g_area_ext
			assign area_fit = {{(tm_pkg::AREA_W-MW){1'b0}}, ao_d[MW-1:0]};
		end
		if (SW >= tm_pkg::PERIM_W) begin : g_perim_cut
			assign perim_fit = perim_sum[tm_pkg::PERIM_W-1:0];
		end else begin : g_perim_ext
			assign perim_fit = {{(tm_pkg::PERIM_W-SW){1'b0}}, perim_sum};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s     <= {vld_s[VD-2:0], s_tvalid};
			out_vld_q <= vld_s[VD-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			area_q  <= area_fit;
			perim_q <= perim_fit;
			angle_q <= ao_d[MW +: tm_pkg::ANGLE_W];
			err_q   <= ao_d[AOW-1];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0000, angle_q, perim_q, area_q};
	assign m_tuser  = err_q;

endmodule

[hw/rtl/tm_delay.sv]
// Enabled delay line used to align the pipeline branches.
module tm_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	generate
		if (DEPTH == 0) begin : g_none
			assign q = d;
		end else begin : g_line
			logic [WIDTH-1:0] dly_s [DEPTH];
			always_ff @(posedge clk) begin
				if (en) begin
					dly_s[0] <= d;
					for (int i = 1; i < DEPTH; i++) begin
						dly_s[i] <= dly_s[i-1];
					end
				end
			end
			assign q = dly_s[DEPTH-1];
		end
	endgenerate

endmodule

[hw/rtl/tm_front.sv]
// Front end: edge vectors, products, cross/dot products and squared side lengths.
module tm_front #(
	parameter int CB = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [CB-1:0]   ax,
	input  logic signed [CB-1:0]   ay,
	input  logic signed [CB-1:0]   bx,
	input  logic signed [CB-1:0]   by_coord,
	input  logic signed [CB-1:0]   cx,
	input  logic signed [CB-1:0]   cy,
	input  logic [1:0]             which_angle,
	output logic signed [2*CB+1:0] crs,
	output logic signed [2*CB+1:0] dot,
	output logic [2*CB:0]          len_ab,
	output logic [2*CB:0]          len_ac,
	output logic [2*CB:0]          len_bc,
	output logic                   err
);

	localparam int DW = CB + 1;
	localparam int PW = 2 * CB + 2;
	localparam int LW = 2 * CB + 1;

	logic signed [DW-1:0] axe, aye, bxe, bye, cxe, cye;
	logic signed [DW-1:0] p0x, p0y, p1x, p1y, p2x, p2y;
	logic                 u_zero, v_zero;

	logic signed [DW-1:0] abx_s1, aby_s1, acx_s1, acy_s1, bcx_s1, bcy_s1;
	logic signed [DW-1:0] ux_s1, uy_s1, vx_s1, vy_s1;
	logic                 err_s1;

	logic signed [PW-1:0] cr0_s2, cr1_s2, dt0_s2, dt1_s2;
	logic signed [PW-1:0] abxx_s2, abyy_s2, acxx_s2, acyy_s2, bcxx_s2, bcyy_s2;
	logic                 err_s2;

	logic signed [PW-1:0] lab_w, lac_w, lbc_w;

	assign axe = {ax[CB-1], ax};
	assign aye = {ay[CB-1], ay};
	assign bxe = {bx[CB-1], bx};
	assign bye = {by_coord[CB-1], by_coord};
	assign cxe = {cx[CB-1], cx};
	assign cye = {cy[CB-1], cy};

	// chosen vertex first, then the next two in rotation
	always_comb begin
		unique case (which_angle)
			tm_pkg::SEL_B: begin
				p0x = bxe; p0y = bye; p1x = cxe; p1y = cye; p2x = axe; p2y = aye;
			end
			tm_pkg::SEL_C: begin
				p0x = cxe; p0y = cye; p1x = axe; p1y = aye; p2x = bxe; p2y = bye;
			end
			tm_pkg::SEL_A, tm_pkg::SEL_NONE: begin
				p0x = axe; p0y = aye; p1x = bxe; p1y = bye; p2x = cxe; p2y = cye;
			end
			default: begin
				p0x = axe; p0y = aye; p1x = bxe; p1y = bye; p2x = cxe; p2y = cye;
			end
		endcase
		u_zero = (p1x == p0x) && (p1y == p0y);
		v_zero = (p2x == p0x) && (p2y == p0y);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			abx_s1 <= bxe - axe;
			aby_s1 <= bye - aye;
			acx_s1 <= cxe - axe;
			acy_s1 <= cye - aye;
			bcx_s1 <= cxe - bxe;
			bcy_s1 <= cye - bye;
			ux_s1  <= p1x - p0x;
			uy_s1  <= p1y - p0y;
			vx_s1  <= p2x - p0x;
			vy_s1  <= p2y - p0y;
			err_s1 <= (which_angle == tm_pkg::SEL_NONE) || u_zero || v_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr0_s2  <= abx_s1 * acy_s1;
			cr1_s2  <= acx_s1 * aby_s1;
			dt0_s2  <= ux_s1 * vx_s1;
			dt1_s2  <= uy_s1 * vy_s1;
			abxx_s2 <= abx_s1 * abx_s1;
			abyy_s2 <= aby_s1 * aby_s1;
			acxx_s2 <= acx_s1 * acx_s1;
			acyy_s2 <= acy_s1 * acy_s1;
			bcxx_s2 <= bcx_s1 * bcx_s1;
			bcyy_s2 <= bcy_s1 * bcy_s1;
			err_s2  <= err_s1;
		end
	end

	assign lab_w = abxx_s2 + abyy_s2;
	assign lac_w = acxx_s2 + acyy_s2;
	assign lbc_w = bcxx_s2 + bcyy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			crs    <= cr0_s2 - cr1_s2;
			dot    <= dt0_s2 + dt1_s2;
			len_ab <= lab_w[LW-1:0];
			len_ac <= lac_w[LW-1:0];
			len_bc <= lbc_w[LW-1:0];
			err    <= err_s2;
		end
	end

endmodule

[hw/rtl/tm_sqrt.sv]
// Pipelined digit-by-digit square root, one root bit per stage, result in Q8.
module tm_sqrt #(
	parameter int CB = 16
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [2*CB:0]                    n,
	output logic [tm_pkg::sqrt_steps(CB)-1:0] root
);

	localparam int LW  = 2 * CB + 1;
	localparam int NIT = tm_pkg::sqrt_steps(CB);
	localparam int NP  = 2 * (NIT - tm_pkg::Q8_FRAC);
	localparam int RW  = NIT + 2;

	logic [NP-1:0]  n_s    [NIT];
	logic [NIT-1:0] root_s [NIT];
	logic [RW-1:0]  rem_s  [NIT];

	genvar i;
	generate
		for (i = 0; i < NIT; i++) begin : g_stage
			localparam int P = NIT - 1 - i;
			logic [NP-1:0]  n_in;
			logic [NIT-1:0] root_in;
			logic [RW-1:0]  rem_in;
			logic [1:0]     pair;
			logic [RW-1:0]  rem_sh, trial;
			logic           ge;

			if (i == 0) begin : g_first
				assign n_in    = {{(NP-LW){1'b0}}, n};
				assign root_in = '0;
				assign rem_in  = '0;
			end else begin : g_next
				assign n_in    = n_s[i-1];
				assign root_in = root_s[i-1];
				assign rem_in  = rem_s[i-1];
			end

			if (P >= tm_pkg::Q8_FRAC) begin : g_pair
				assign pair = n_in[2*(P-tm_pkg::Q8_FRAC)+1 -: 2];
			end else begin : g_frac
				assign pair = 2'b00;
			end

			assign rem_sh = {rem_in[RW-3:0], pair};
			assign trial  = {root_in, 2'b01};
			assign ge     = rem_sh >= trial;

			always_ff @(posedge clk) begin
				if (en) begin
					n_s[i]    <= n_in;
					root_s[i] <= {root_in[NIT-2:0], ge};
					rem_s[i]  <= ge ? rem_sh - trial : rem_sh;
				end
			end
		end
	endgenerate

	assign root = root_s[NIT-1];

endmodule

[hw/rtl/tm_angle.sv]
// Angle path: operand setup, stepwise normalization, CORDIC vectoring and rounding.
module tm_angle #(
	parameter int CB = 16
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [2*CB+1:0]    crs,
	input  logic signed [2*CB+1:0]    dot,
	input  logic                      err,
	output logic [2*CB:0]             area,
	output logic [tm_pkg::ANGLE_W-1:0] angle,
	output logic                      err_out
);

	localparam int PW = 2 * CB + 2;
	localparam int MW = 2 * CB + 1;
	localparam int NW = MW + tm_pkg::NORM_LSB + 1;
	localparam int NS = $clog2(MW + 1);
	localparam int CW = tm_pkg::CORDIC_W;
	localparam int ZW = tm_pkg::Z_W;
	localparam int NC = tm_pkg::CORDIC_STEPS;
	localparam int XW = tm_pkg::NORM_LSB + 1;

	typedef struct packed {
		logic [MW-1:0] area;
		logic          neg;
		logic          flag;
		logic          err;
	} side_t;

	logic [PW-1:0] crs_abs, dot_neg;
	logic [MW-1:0] x_s1, y_s1;
	side_t         sb_s1;

	logic [MW-1:0] m_w;
	logic [NW-1:0] xn_s [NS+1];
	logic [NW-1:0] yn_s [NS+1];
	logic [NW-1:0] mn_s [NS+1];
	side_t         sn_s [NS+1];

	logic signed [CW-1:0] xc_s [NC];
	logic signed [CW-1:0] yc_s [NC];
	logic signed [ZW-1:0] zc_s [NC];
	side_t                sc_s [NC];

	logic signed [ZW:0]   r_w, rs_w;

	assign crs_abs = crs[PW-1] ? PW'(-crs) : PW'(crs);
	assign dot_neg = PW'(-dot);

	// a negative dot product rotates the vector by 90 degrees up front
	always_ff @(posedge clk) begin
		if (en) begin
			if (dot[PW-1]) begin
				x_s1 <= crs_abs[MW-1:0];
				y_s1 <= dot_neg[MW-1:0];
			end else begin
				x_s1 <= dot[MW-1:0];
				y_s1 <= crs_abs[MW-1:0];
			end
			sb_s1.area <= crs_abs[MW-1:0];
			sb_s1.neg  <= dot[PW-1];
			sb_s1.flag <= err;
			sb_s1.err  <= err;
		end
	end

	assign m_w = (x_s1 > y_s1) ? x_s1 : y_s1;

	// values sit 41 bits up so that one right shift search covers both directions
	always_ff @(posedge clk) begin
		if (en) begin
			xn_s[0]         <= {x_s1, {XW{1'b0}}};
			yn_s[0]         <= {y_s1, {XW{1'b0}}};
			mn_s[0]         <= {m_w, {XW{1'b0}}};
			sn_s[0]         <= '{area: sb_s1.area, neg: sb_s1.neg,
				flag: sb_s1.flag || (m_w == '0), err: sb_s1.err};
		end
	end

	genvar j;
	generate
		for (j = 0; j < NS; j++) begin : g_norm
			localparam int K = 1 << (NS - 1 - j);
			logic sh;
			assign sh = |mn_s[j][NW-1:tm_pkg::NORM_LSB+K];
			always_ff @(posedge clk) begin
				if (en) begin
					xn_s[j+1] <= sh ? (xn_s[j] >> K) : xn_s[j];
					yn_s[j+1] <= sh ? (yn_s[j] >> K) : yn_s[j];
					mn_s[j+1] <= sh ? (mn_s[j] >> K) : mn_s[j];
					sn_s[j+1] <= sn_s[j];
				end
			end
		end

		for (j = 0; j < NC; j++) begin : g_cordic
			logic signed [CW-1:0] x_in, y_in, dx, dy;
			logic signed [ZW-1:0] z_in, at;
			side_t                s_in;

			if (j == 0) begin : g_first
				assign x_in = signed'({{(CW-XW){1'b0}}, xn_s[NS][XW-1:0]});
				assign y_in = signed'({{(CW-XW){1'b0}}, yn_s[NS][XW-1:0]});
				assign z_in = sn_s[NS].neg ? ZW'(tm_pkg::Z_RIGHT) : '0;
				assign s_in = sn_s[NS];
			end else begin : g_next
				assign x_in = xc_s[j-1];
				assign y_in = yc_s[j-1];
				assign z_in = zc_s[j-1];
				assign s_in = sc_s[j-1];
			end

			assign dx = y_in >>> j;
			assign dy = x_in >>> j;
			assign at = signed'({{(ZW-22){1'b0}}, tm_pkg::ATAN_Q16[j]});

			always_ff @(posedge clk) begin
				if (en) begin
					if (y_in > 0) begin
						xc_s[j] <= x_in + dx;
						yc_s[j] <= y_in - dy;
						zc_s[j] <= z_in + at;
					end else begin
						xc_s[j] <= x_in - dx;
						yc_s[j] <= y_in + dy;
						zc_s[j] <= z_in - at;
					end
					sc_s[j] <= s_in;
				end
			end
		end
	endgenerate

	assign r_w  = {zc_s[NC-1][ZW-1], zc_s[NC-1]} + (ZW+1)'(tm_pkg::ROUND_HALF);
	assign rs_w = r_w >>> tm_pkg::Q8_FRAC;

	always_ff @(posedge clk) begin
		if (en) begin
			area    <= sc_s[NC-1].area;
			err_out <= sc_s[NC-1].err;
			if (sc_s[NC-1].flag || r_w[ZW]) begin
				angle <= '0;
			end else if (rs_w[ZW-1:0] > ZW'(tm_pkg::ANGLE_MAX)) begin
				angle <= tm_pkg::ANGLE_W'(tm_pkg::ANGLE_MAX);
			end else begin
				angle <= rs_w[tm_pkg::ANGLE_W-1:0];
			end
		end
	end

endmodule

[dv/tb.sv]
// Testbench for triangle_measure: random and directed triangles checked against a local model.
`timescale 1ns / 1ps

module tb;

	localparam int CB = 16;
	localparam int DW = ((6*CB+7)/8)*8;
	localparam int LAT = 40;
	localparam longint NORM_LOW_V  = 64'sd1 <<< 40;
	localparam longint NORM_HIGH_V = 64'sd1 <<< 41;

	typedef struct packed {
		logic [1:0]    sel;
		logic [DW-1:0] coords;
	} tri_t;

	typedef struct packed {
		logic [tm_pkg::AREA_W-1:0]  area;
		logic [tm_pkg::PERIM_W-1:0] perim;
		logic [tm_pkg::ANGLE_W-1:0] angle;
		logic                       err;
	} meas_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
	logic [DW-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic [79:0] m_tdata;

	tri_t  tri_q[$];
	meas_t want_q[$];
	int    errors = 0;
	bit    src_hold;      // sender pause until drained
	bit    quiet_src, quiet_snk;
	bit    snk_hold_req;  // starts the long receiver hold-off
	bit    snk_hold = 1'b0;

	triangle_measure #(.COORD_BITS(CB)) u_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint coord(input tri_t t, input int i);
		return longint'($signed(t.coords[i*CB +: CB]));
	endfunction

	function automatic longint root_q8(input longint unsigned n);
		longint unsigned root, rem, pr, trial;
		root = 0;
		rem = 0;
		for (int p = 39; p >= 0; p--) begin
			pr = (p >= 8) ? ((n >> (2*(p-8))) & 3) : 0;
			rem = (rem << 2) | pr;
			trial = (root << 2) | 1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 1;
			end else begin
				root = root << 1;
			end
		end
		return longint'(root);
	endfunction

	function automatic longint dist2(input longint dx, input longint dy);
		return dx*dx + dy*dy;
	endfunction

	function automatic longint vector_angle(input longint dot, input longint crs);
		longint x, y, z, m, r, dx, dy;
		z = 0;
		if (dot < 0) begin
			x = crs;
			y = -dot;
			z = tm_pkg::Z_RIGHT;
		end else begin
			x = dot;
			y = crs;
		end
		m = (x > y) ? x : y;
		if (m <= 0) return 0;
		while (m >= NORM_HIGH_V) begin
			m = m >>> 1; x = x >>> 1; y = y >>> 1;
		end
		while (m < NORM_LOW_V) begin
			m = m <<< 1; x = x <<< 1; y = y <<< 1;
		end
		for (int i = 0; i < tm_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;   // arithmetic shift is floor division
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += longint'(tm_pkg::ATAN_Q16[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(tm_pkg::ATAN_Q16[i]);
			end
		end
		r = z + tm_pkg::ROUND_HALF;
		if (r < 0) r = 0;
		r = r >>> 8;
		if (r > tm_pkg::ANGLE_MAX) r = tm_pkg::ANGLE_MAX;
		return r;
	endfunction

	function automatic meas_t measure(input tri_t t);
		meas_t o;
		longint px[3], py[3], crs, area, ux, uy, vx, vy;
		int v0, v1, v2;
		for (int i = 0; i < 3; i++) begin
			px[i] = coord(t, 2*i);
			py[i] = coord(t, 2*i+1);
		end
		crs = (px[1]-px[0])*(py[2]-py[0]) - (px[2]-px[0])*(py[1]-py[0]);
		area = crs < 0 ? -crs : crs;
		o.area = area[tm_pkg::AREA_W-1:0];
		o.perim = tm_pkg::PERIM_W'(root_q8(dist2(px[1]-px[0], py[1]-py[0]))
			+ root_q8(dist2(px[2]-px[0], py[2]-py[0]))
			+ root_q8(dist2(px[2]-px[1], py[2]-py[1])));
		o.angle = '0;
		o.err = 1'b0;
		if (t.sel == tm_pkg::SEL_NONE) begin
			o.err = 1'b1;
		end else begin
			v0 = int'(t.sel) - 1;
			v1 = (v0 + 1) % 3;
			v2 = (v0 + 2) % 3;
			ux = px[v1]-px[v0]; uy = py[v1]-py[v0];
			vx = px[v2]-px[v0]; vy = py[v2]-py[v0];
			if ((ux == 0 && uy == 0) || (vx == 0 && vy == 0))
				o.err = 1'b1;
			else
				o.angle = tm_pkg::ANGLE_W'(vector_angle(ux*vx + uy*vy, area));
		end
		return o;
	endfunction

	function automatic tri_t make_tri(input int x[6], input logic [1:0] s);
		tri_t t;
		t.coords = '0;
		for (int i = 0; i < 6; i++) t.coords[i*CB +: CB] = x[i][CB-1:0];
		t.sel = s;
		return t;
	endfunction

	// mostly small coordinates to reach near-degenerate shapes; some full range
	function automatic int rnd_coord(input int mode);
		case (mode)
			0: return int'($signed(16'($urandom)));
			1: return $urandom_range(0, 20) - 10;
			default: return $urandom_range(0, 2000) - 1000;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) want_q.push_back(measure({s_tuser, s_tdata}));
			if (tri_q.size() > 0 && !src_hold && (quiet_src || $urandom_range(0, 99) >= 27)) begin
				s_tvalid <= 1'b1;
				{s_tuser, s_tdata} <= tri_q.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted in cycles
	initial begin
		wait (snk_hold_req);
		@(posedge clk);
		snk_hold <= 1'b1;
		repeat (200) @(posedge clk);
		snk_hold <= 1'b0;
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (want_q.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					meas_t w;
					w = want_q.pop_front();
					if (m_tdata[tm_pkg::AREA_W-1:0] !== w.area) begin
						$error("area_doubled exp %0d got %0d", w.area,
							m_tdata[tm_pkg::AREA_W-1:0]);
						errors++;
					end
					if (m_tdata[tm_pkg::AREA_W +: tm_pkg::PERIM_W] !== w.perim) begin
						$error("perimeter_q8 exp %0d got %0d", w.perim,
							m_tdata[tm_pkg::AREA_W +: tm_pkg::PERIM_W]);
						errors++;
					end
					if (m_tdata[tm_pkg::AREA_W+tm_pkg::PERIM_W +: tm_pkg::ANGLE_W]
						!== w.angle) begin
						$error("angle_deg_q8 exp %0d got %0d", w.angle,
							m_tdata[tm_pkg::AREA_W+tm_pkg::PERIM_W +: tm_pkg::ANGLE_W]);
						errors++;
					end
					if (m_tuser !== w.err) begin
						$error("error_flag exp %0d got %0d", w.err, m_tuser);
						errors++;
					end
				end
			end
			if (snk_hold) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet_snk || $urandom_range(0, 99) >= 27;
			end
		end
	end

	initial begin
		#50_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int x[6];
		int mode;
		src_hold = 0;
		quiet_src = 0;
		quiet_snk = 0;
		snk_hold_req = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, each selector, degenerate and collinear shapes
		x = '{-32768, -32768, 32767, -32768, -32768, 32767};
		for (int s = 0; s < 4; s++) tri_q.push_back(make_tri(x, 2'(s)));
		x = '{32767, 32767, -32768, 32767, 32767, -32768};
		tri_q.push_back(make_tri(x, tm_pkg::SEL_A));
		x = '{-32768, -32768, 32767, 32767, -32768, -32768};
		for (int s = 1; s < 4; s++) tri_q.push_back(make_tri(x, 2'(s)));
		x = '{5, 5, 5, 5, 5, 5};
		tri_q.push_back(make_tri(x, tm_pkg::SEL_B));
		x = '{0, 0, 10, 0, 20, 0};
		for (int s = 1; s < 4; s++) tri_q.push_back(make_tri(x, 2'(s)));
		x = '{0, 0, 3, 0, 0, 4};
		for (int s = 0; s < 4; s++) tri_q.push_back(make_tri(x, 2'(s)));
		x = '{0, 0, -100, 1, 100, 1};
		tri_q.push_back(make_tri(x, tm_pkg::SEL_A));
		x = '{-1, -1, -1, -1, -1, -1};
		tri_q.push_back(make_tri(x, tm_pkg::SEL_C));

		// long receiver hold-off while the sender keeps offering
		snk_hold_req = 1;
		quiet_src = 1;
		for (int n = 0; n < 60; n++) begin
			mode = $urandom_range(0, 2);
			foreach (x[i]) x[i] = rnd_coord(mode);
			tri_q.push_back(make_tri(x, 2'($urandom_range(0, 3))));
		end
		wait (tri_q.size() == 0);
		quiet_src = 0;

		// sender pause until every result is back
		src_hold = 1;
		wait (want_q.size() == 0 && !s_tvalid);
		repeat (LAT + 5) @(posedge clk);
		src_hold = 0;

		for (int n = 0; n < 580; n++) begin
			mode = $urandom_range(0, 2);
			foreach (x[i]) x[i] = rnd_coord(mode);
			if ($urandom_range(0, 9) == 0) begin
				x[2] = x[0];   // repeated vertex
				x[3] = x[1];
			end
			tri_q.push_back(make_tri(x, 2'($urandom_range(0, 3))));
			if (n == 200) begin
				wait (tri_q.size() < 5);
				quiet_src = 1;
				quiet_snk = 1;
			end
			if (n == 350) begin
				wait (tri_q.size() < 5);
				quiet_src = 0;
				quiet_snk = 0;
			end
		end

		wait (tri_q.size() == 0);
		@(posedge clk);
		wait (!s_tvalid && want_q.size() == 0);
		repeat (LAT + 10) @(posedge clk);
		if (errors == 0 && want_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
